@@ rtl/iiel_pkg.sv @@
`timescale 1ns / 1ps
package iiel_pkg;

  // List capacity and derived widths
  localparam int DEPTH  = 16;
  localparam int CNT_W  = 5;   // fixed by the length and position ports
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  // Request codes
  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_DROP    = 3'd1,
    MODE_READ    = 3'd2,
    MODE_INSERT  = 3'd3,
    MODE_ERASE   = 3'd4,
    MODE_SETLEN  = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Datapath cell operations
  typedef enum logic [1:0] {
    DP_HOLD,
    DP_INSERT,
    DP_ERASE,
    DP_ZERO
  } dp_op_t;

  // Controller state: whether a result word is held at the output
  typedef enum logic {
    S_IDLE,
    S_HOLD
  } ctl_state_t;

  // Command from controller to datapath
  typedef struct packed {
    dp_op_t                    op;
    logic [CNT_W-1:0]          idx;      // insert/erase/read position
    logic [CNT_W-1:0]          lo;       // zero fill from (inclusive)
    logic [CNT_W-1:0]          hi;       // zero fill to (exclusive)
    logic signed [WORD_W-1:0]  value;
    logic                      rd_load;  // update read data register
    logic                      rd_hit;   // read is in range
  } dp_cmd_t;

endpackage

@@ rtl/indexed_insert_erase_list_top.sv @@
`timescale 1ns / 1ps
// Ordered list of up to 16 signed 32-bit words, held in a row of register
// cells with a length count.
// Input channel (in_valid/in_ready): one request word with in_mode,
// in_position, in_value and in_new_length. Modes: append, drop last, read,
// insert, erase, set length, clear.
// Output channel (out_valid/out_ready): exactly one result word per request
// with out_read_data, out_length, out_is_empty and out_status.
// The result is valid the cycle after the request is accepted.
// Throughput: one request per cycle; insert and erase shift every cell
// against its neighbor in the same cycle, and the result sits in an output
// register, so the next request is taken while the receiver takes this one.
// When the receiver stalls, the held result stays put and in_ready drops
// until it is taken.
// Reset (rst_n low, synchronous) empties the list and drops any held
// result; cell contents are not cleared and are never read before written.
module indexed_insert_erase_list_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_mode,
  input  logic [iiel_pkg::CNT_W-1:0]        in_position,
  input  logic signed [iiel_pkg::WORD_W-1:0] in_value,
  input  logic [iiel_pkg::CNT_W-1:0]        in_new_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [iiel_pkg::WORD_W-1:0] out_read_data,
  output logic [iiel_pkg::CNT_W-1:0]        out_length,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);
  import iiel_pkg::*;

  dp_cmd_t cmd;

  iiel_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_new_length (in_new_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_length    (out_length),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status),
    .cmd           (cmd)
  );

  iiel_datapath u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (out_read_data)
  );

endmodule

@@ rtl/iiel_datapath.sv @@
`timescale 1ns / 1ps
module iiel_datapath (
  input  logic                              clk,
  input  iiel_pkg::dp_cmd_t                 cmd,
  output logic signed [iiel_pkg::WORD_W-1:0] rd_data
);
  import iiel_pkg::*;

  logic signed [WORD_W-1:0] cell_r   [DEPTH];
  logic signed [WORD_W-1:0] cell_nxt [DEPTH];
  logic signed [WORD_W-1:0] rd_r;
  logic signed [WORD_W-1:0] rd_nxt;

  // Each cell picks its own value, the inserted value, its lower or upper neighbor, or zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] upper;
    logic signed [WORD_W-1:0] lower;

    if (i < DEPTH - 1) begin : g_up
      assign upper = cell_r[i+1];
    end else begin : g_top
      assign upper = cell_r[i];
    end

    if (i > 0) begin : g_lo
      assign lower = cell_r[i-1];
    end else begin : g_bot
      assign lower = cell_r[i];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      unique case (cmd.op)
        DP_INSERT: begin
          if (CNT_W'(i) == cmd.idx) cell_nxt[i] = cmd.value;
          else if (CNT_W'(i) > cmd.idx) cell_nxt[i] = lower;
        end
        DP_ERASE: begin
          if (CNT_W'(i) >= cmd.idx) cell_nxt[i] = upper;
        end
        DP_ZERO: begin
          if (CNT_W'(i) >= cmd.lo && CNT_W'(i) < cmd.hi) cell_nxt[i] = '0;
        end
        default: cell_nxt[i] = cell_r[i];
      endcase
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // Read port: one selected cell, zero when out of range
  always_comb begin
    rd_nxt = rd_r;
    if (cmd.rd_load) begin
      rd_nxt = cmd.rd_hit ? cell_r[cmd.idx[IDX_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
  end

  assign rd_data = rd_r;

endmodule

@@ rtl/iiel_ctrl.sv @@
`timescale 1ns / 1ps
module iiel_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_mode,
  input  logic [iiel_pkg::CNT_W-1:0]        in_position,
  input  logic signed [iiel_pkg::WORD_W-1:0] in_value,
  input  logic [iiel_pkg::CNT_W-1:0]        in_new_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iiel_pkg::CNT_W-1:0]        out_length,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status,
  output iiel_pkg::dp_cmd_t                 cmd
);
  import iiel_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] new_count;
  status_t          new_status;
  logic             accept;

  assign in_ready = (state_r == S_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode request: status, resulting length and cell command
  always_comb begin
    new_count   = count_r;
    new_status  = STAT_OK;
    cmd         = '0;
    cmd.op      = DP_HOLD;
    cmd.idx     = in_position;
    cmd.lo      = count_r;
    cmd.hi      = in_new_length;
    cmd.value   = in_value;
    cmd.rd_load = accept;
    cmd.rd_hit  = 1'b0;
    unique case (mode_t'(in_mode))
      MODE_APPEND: begin
        if (count_r >= CNT_W'(DEPTH)) begin
          new_status = STAT_FULL;
        end else begin
          cmd.op    = DP_INSERT;
          cmd.idx   = count_r;
          new_count = count_r + 1'b1;
        end
      end
      MODE_DROP: begin
        if (count_r != '0) new_count = count_r - 1'b1;
      end
      MODE_READ: begin
        if (in_position >= count_r) new_status = STAT_RANGE;
        else cmd.rd_hit = 1'b1;
      end
      MODE_INSERT: begin
        if (in_position > count_r) begin
          new_status = STAT_RANGE;
        end else if (count_r >= CNT_W'(DEPTH)) begin
          new_status = STAT_FULL;
        end else begin
          cmd.op    = DP_INSERT;
          new_count = count_r + 1'b1;
        end
      end
      MODE_ERASE: begin
        if (in_position >= count_r) begin
          new_status = STAT_RANGE;
        end else begin
          cmd.op    = DP_ERASE;
          new_count = count_r - 1'b1;
        end
      end
      MODE_SETLEN: begin
        if (in_new_length > CNT_W'(DEPTH)) begin
          new_status = STAT_RANGE;
        end else begin
          cmd.op    = DP_ZERO;
          new_count = in_new_length;
        end
      end
      MODE_CLEAR: new_count = '0;
      default: new_count = count_r;
    endcase
    if (!accept) cmd.op = DP_HOLD;
  end

  // Next state and result registers
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    if (accept) begin
      state_nxt  = S_HOLD;
      count_nxt  = new_count;
      len_nxt    = new_count;
      status_nxt = new_status;
    end else if (out_ready) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      len_r    <= '0;
      status_r <= STAT_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = (state_r == S_HOLD);
  assign out_length   = len_r;
  assign out_is_empty = (len_r == '0);
  assign out_status   = status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_r == STAT_FULL |-> len_r == CNT_W'(DEPTH))
    else $error("full status with list not full");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_CLEAR |=> out_length == '0 && count_r == '0)
    else $error("clear left entries");

  a_len_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> len_r == count_r)
    else $error("reported length differs from list length");
`endif

endmodule
